/* rtl/core/dklp_pkg.sv */
// shared types, constants and commands for the dual-key linear probe table
package dklp_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int SIZE_W = 17;
   localparam int KEY_W = 32;
   localparam int PAIR_W = 2 * KEY_W;
   localparam int HASH_MULT = 9123;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd50000;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef struct packed {
      logic operation;
      logic signed [KEY_W-1:0] key_x;
      logic signed [KEY_W-1:0] key_y;
   } req_type;

   typedef struct packed {
      logic hit;
      logic table_full;
      logic [SIZE_W-1:0] slots_used;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_DIV,
      ST_READ,
      ST_WAIT,
      ST_CHECK,
      ST_NEXT_KEY,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic start_hash;
      logic div_step;
      logic set_pos;
      logic advance;
      logic write_slot;
      logic set_full;
      logic set_hit;
      logic use_y;
      logic load_rsp;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic div_done;
      logic slot_valid;
      logic key_match;
      logic probe_last;
      logic is_insert;
   } status_type;

endpackage

/* rtl/core/dklp_ram.sv */
// generic single-port ram with registered read
module dklp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dklp_datapath.sv */
// hash divider, probe pointer, slot memories and result registers
module dklp_datapath
   import dklp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SIZE_W-1:0] table_size,
   input  req_type           req_data,
   input  cmd_type           cmd,
   output status_type        status,
   output rsp_type           rsp_data
);

   logic [ADDR_W-1:0]   clear_ff, clear_in;
   req_type             req_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [KEY_W-1:0]    rem_ff;              // magnitude, shifted out msb first
   logic [5:0]          bit_ff;
   logic [SIZE_W:0]     part_ff;
   logic [ADDR_W-1:0]   pos_ff;
   logic [SIZE_W-1:0]   probe_ff;
   logic                hit_ff, full_ff;
   logic [SIZE_W-1:0]   count_ff;
   rsp_type             rsp_ff;

   logic [KEY_W-1:0]    key_sel;
   logic [KEY_W-1:0]    product;
   logic [KEY_W-1:0]    mag;
   logic [SIZE_W:0]     trial;
   logic [ADDR_W-1:0]   ram_addr;
   logic                valid_rd;
   logic [PAIR_W-1:0]   pair_rd;
   logic [SIZE_W-1:0]   eff_size;

   always_comb begin
      eff_size = table_size;
      if (table_size < SIZE_W'(2)) eff_size = SIZE_W'(2);
      if (table_size > SIZE_W'(TABLE_DEPTH)) eff_size = SIZE_W'(TABLE_DEPTH);
   end

   assign key_sel = cmd.use_y ? req_ff.key_y : req_ff.key_x;
   assign product = key_sel * KEY_W'(HASH_MULT);
   assign mag = product[KEY_W-1] ? (KEY_W'(0) - product) : product;
   assign trial = {part_ff[SIZE_W-1:0], rem_ff[KEY_W-1]};

   // request capture, restoring remainder division, probe pointer and response register
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
         size_ff <= eff_size;
      end
      if (cmd.start_hash) begin
         rem_ff <= mag;
         part_ff <= '0;
         bit_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= {rem_ff[KEY_W-2:0], 1'b0};
         part_ff <= (trial >= {1'b0, size_ff}) ? trial - {1'b0, size_ff} : trial;
         bit_ff <= bit_ff + 6'd1;
      end
      if (cmd.set_pos) begin
         pos_ff <= part_ff[ADDR_W-1:0];
         probe_ff <= '0;
      end else if (cmd.advance) begin
         pos_ff <= ({1'b0, pos_ff} + 1'b1 >= size_ff) ? '0 : pos_ff + 1'b1;
         probe_ff <= probe_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= '{hit: hit_ff, table_full: full_ff, slots_used: count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '0;
         hit_ff <= 1'b0;
         full_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         clear_ff <= clear_in;
         if (cmd.load_req) begin
            hit_ff <= 1'b0;
            full_ff <= 1'b0;
         end
         if (cmd.set_hit) hit_ff <= 1'b1;
         if (cmd.set_full) full_ff <= 1'b1;
         if (cmd.write_slot) count_ff <= count_ff + 1'b1;
      end
   end

   assign clear_in = cmd.clear_step ? clear_ff + 1'b1 : clear_ff;
   assign ram_addr = cmd.clear_step ? clear_ff : pos_ff;

   dklp_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_step | cmd.write_slot),
      .addr    (ram_addr),
      .wr_data (cmd.write_slot),
      .rd_data (valid_rd)
   );

   dklp_ram #(.WIDTH(PAIR_W), .DEPTH(TABLE_DEPTH)) u_pair_ram (
      .clock   (clock),
      .wr_en   (cmd.write_slot),
      .addr    (ram_addr),
      .wr_data ({req_ff.key_x, req_ff.key_y}),
      .rd_data (pair_rd)
   );

   assign status.clear_last = (clear_ff == {ADDR_W{1'b1}});
   assign status.div_done = (bit_ff == 6'(KEY_W - 1));
   assign status.slot_valid = valid_rd;
   assign status.key_match = cmd.use_y ? (pair_rd[KEY_W-1:0] == req_ff.key_y)
                                       : (pair_rd[PAIR_W-1:KEY_W] == req_ff.key_x);
   assign status.probe_last = (probe_ff + 1'b1 >= size_ff);
   assign status.is_insert = (req_ff.operation == OP_INSERT);
   assign rsp_data = rsp_ff;

endmodule

/* rtl/core/dklp_ctrl.sv */
// controller state machine for clearing, hashing and probing
module dklp_ctrl
   import dklp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      use_y_ff, use_y_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         use_y_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         use_y_ff <= use_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      use_y_in = use_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      cmd.use_y = use_y_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               use_y_in = 1'b0;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.start_hash = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.set_pos = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.slot_valid) begin
               if (status.is_insert) cmd.write_slot = 1'b1;
               state_in = ST_NEXT_KEY;
            end else if (!status.is_insert && status.key_match) begin
               cmd.set_hit = 1'b1;
               state_in = ST_DONE;
            end else if (status.probe_last) begin
               cmd.set_full = 1'b1;
               state_in = ST_NEXT_KEY;
            end else begin
               cmd.advance = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_NEXT_KEY: begin
            if (use_y_ff) begin
               state_in = ST_DONE;
            end else begin
               use_y_in = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/dual_key_linear_probe_table.sv */
// top level of the dual-key linear probe table
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_type
//  rsp     | out       | rsp_valid/rsp_stall | rsp_type
//  csr     | in        | csr_wr_en           | table_size
// after reset a clearing pass over every slot empties the valid map; no beat is taken
// an item probes from the hash of key_x and then, unless a lookup hits on key_x, from the
// hash of key_y; each key is reduced by a 32-step restoring remainder before probing
// the result waits in an output register; the next beat is taken while it waits
module dual_key_linear_probe_table
   import dklp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   logic [SIZE_W-1:0] table_size_ff;
   cmd_type           cmd;
   status_type        status;

   always_ff @(posedge clock) begin
      if (reset) table_size_ff <= SIZE_RESET;
      else if (csr_wr_en) table_size_ff <= csr_wr_data;
   end

   dklp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .status, .cmd
   );

   dklp_datapath u_datapath (
      .clock, .reset, .table_size(table_size_ff), .req_data, .cmd, .status, .rsp_data
   );

   a_no_write_on_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> status.is_insert) else $error("write on lookup");
   a_hit_only_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.set_hit |-> !status.is_insert) else $error("hit on insert");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("rsp dropped");

endmodule
